>>> rtl/vab_pkg.sv
`timescale 1ns / 1ps
// shared constants, operation codes and structs of the vm alu/branch unit
// no dependencies

package vab_pkg;

  localparam int WORD_WIDTH = 16;
  localparam int CNT_W      = $clog2(WORD_WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_WIDTH - 1);

  typedef enum logic [4:0] {
    FN_HLT = 5'd0,
    FN_NOP = 5'd1,
    FN_CMP = 5'd2,
    FN_MOV = 5'd3,
    FN_INC = 5'd4,
    FN_DEC = 5'd5,
    FN_ADD = 5'd6,
    FN_SUB = 5'd7,
    FN_MUL = 5'd8,
    FN_DIV = 5'd9,
    FN_SHL = 5'd10,
    FN_SHR = 5'd11,
    FN_JMP = 5'd12,
    FN_JE  = 5'd13,
    FN_JNE = 5'd14,
    FN_JZ  = 5'd15,
    FN_JNZ = 5'd16,
    FN_JL  = 5'd17,
    FN_JLE = 5'd18,
    FN_JG  = 5'd19,
    FN_JGE = 5'd20
  } func_t;

  typedef enum logic [2:0] {
    AOP_MOV,
    AOP_INC,
    AOP_DEC,
    AOP_ADD,
    AOP_SUB,
    AOP_SHL,
    AOP_SHR,
    AOP_CMP
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctrl_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  typedef struct packed {
    logic                  done;
    logic [WORD_WIDTH-1:0] value;
    logic                  carry;
    logic                  ne;
    logic                  nz;
  } alu_res_t;

  typedef struct packed {
    logic                  done;
    logic [WORD_WIDTH-1:0] value;
    logic                  ovf;
  } md_res_t;

  typedef struct packed {
    logic halt;
    logic underflow;
    logic overflow;
    logic zero;
    logic equal;
    logic less;
    logic greater;
  } flags_t;

endpackage

>>> rtl/vab_req_if.sv
`timescale 1ns / 1ps
// request channel: operation code, accumulator and source operand
// no dependencies

interface vab_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  func;
  logic [15:0] acc_value;
  logic [15:0] src_value;

  modport source (output valid, func, acc_value, src_value, input ready);
  modport sink   (input valid, func, acc_value, src_value, output ready);
endinterface

>>> rtl/vab_rsp_if.sv
`timescale 1ns / 1ps
// response channel: destination write, jump and flag register
// no dependencies

interface vab_rsp_if;
  logic        valid;
  logic        ready;
  logic        dst_write;
  logic [15:0] dst_value;
  logic        pc_load;
  logic [15:0] new_pc;
  logic        flag_greater;
  logic        flag_less;
  logic        flag_equal;
  logic        flag_zero;
  logic        flag_overflow;
  logic        flag_underflow;
  logic        halted;

  modport source (output valid, dst_write, dst_value, pc_load, new_pc, flag_greater,
                  flag_less, flag_equal, flag_zero, flag_overflow, flag_underflow,
                  halted, input ready);
  modport sink   (input valid, dst_write, dst_value, pc_load, new_pc, flag_greater,
                  flag_less, flag_equal, flag_zero, flag_overflow, flag_underflow,
                  halted, output ready);
endinterface

>>> rtl/vm_alu_branch_unit.sv
`timescale 1ns / 1ps
// execute unit of the vm: decodes the word, runs the serial alu or the mul/div
// unit, keeps the flag register and resolves jumps; depends on vab_pkg and both
// channel interfaces, instantiates vab_serial_alu and vab_muldiv
// arithmetic, move, shift and compare words run on the one-bit-per-cycle serial alu,
// multiply and divide on the radix-2 mul/div loop; halt, nop, jump and unused codes
// go straight to the finish state; one word in flight at a time, the next word is
// taken the cycle after the result is registered
// reset (synchronous, active high) clears all flags and empties the result register

module vm_alu_branch_unit import vab_pkg::*; (
  input logic      clk,
  input logic      rst,
  vab_req_if.sink  req,
  vab_rsp_if.source rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_ALU, ST_MD, ST_FINISH} state_t;

  state_t                state;
  logic [4:0]            func_q;
  logic [WORD_WIDTH-1:0] src_q;
  flags_t                flags;

  logic                  rsp_valid;
  logic                  rsp_dst_write;
  logic [WORD_WIDTH-1:0] rsp_dst_value;
  logic                  rsp_pc_load;
  logic [WORD_WIDTH-1:0] rsp_new_pc;

  alu_ctrl_t alu_ctrl;
  md_ctrl_t  md_ctrl;
  alu_res_t  alu_res;
  md_res_t   md_res;

  logic   accept;
  logic   use_alu;
  logic   use_md;
  logic   slot_free;
  logic   wr;
  logic   jump;
  logic [WORD_WIDTH-1:0] wr_value;
  flags_t flags_next;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign slot_free = !rsp_valid || rsp.ready;

  // decode of the incoming word
  always_comb begin
    use_alu     = 1'b0;
    use_md      = 1'b0;
    alu_ctrl.op = AOP_MOV;
    md_ctrl.is_div = 1'b0;
    unique case (req.func)
      FN_CMP: begin use_alu = 1'b1; alu_ctrl.op = AOP_CMP; end
      FN_MOV: begin use_alu = 1'b1; alu_ctrl.op = AOP_MOV; end
      FN_INC: begin use_alu = 1'b1; alu_ctrl.op = AOP_INC; end
      FN_DEC: begin use_alu = 1'b1; alu_ctrl.op = AOP_DEC; end
      FN_ADD: begin use_alu = 1'b1; alu_ctrl.op = AOP_ADD; end
      FN_SUB: begin use_alu = 1'b1; alu_ctrl.op = AOP_SUB; end
      FN_SHL: begin use_alu = 1'b1; alu_ctrl.op = AOP_SHL; end
      FN_SHR: begin use_alu = 1'b1; alu_ctrl.op = AOP_SHR; end
      FN_MUL: begin use_md = 1'b1; md_ctrl.is_div = 1'b0; end
      FN_DIV: begin use_md = 1'b1; md_ctrl.is_div = 1'b1; end
      default: begin use_alu = 1'b0; use_md = 1'b0; end
    endcase
    alu_ctrl.start = accept && use_alu;
    md_ctrl.start  = accept && use_md;
  end

  vab_serial_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctrl (alu_ctrl),
    .a    (req.acc_value),
    .s    (req.src_value),
    .res  (alu_res)
  );

  vab_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .ctrl (md_ctrl),
    .a    (req.acc_value),
    .s    (req.src_value),
    .res  (md_res)
  );

  // result and flag update of the finished word
  always_comb begin
    flags_next = flags;
    wr         = 1'b0;
    jump       = 1'b0;
    wr_value   = alu_res.value;
    unique case (func_q)
      FN_HLT: flags_next.halt = 1'b1;
      FN_CMP: begin
        flags_next.greater = alu_res.carry & alu_res.ne;
        flags_next.less    = !alu_res.carry;
        flags_next.equal   = !alu_res.ne;
        flags_next.zero    = !alu_res.nz;
      end
      FN_MOV, FN_SHL, FN_SHR: wr = 1'b1;
      FN_INC, FN_ADD: begin
        wr = 1'b1;
        flags_next.overflow = alu_res.carry;
      end
      FN_DEC, FN_SUB: begin
        wr = 1'b1;
        flags_next.underflow = !alu_res.carry;
      end
      FN_MUL: begin
        wr       = 1'b1;
        wr_value = md_res.value;
        flags_next.overflow = md_res.ovf;
      end
      FN_DIV: begin
        wr       = 1'b1;
        wr_value = md_res.value;
      end
      FN_JMP: jump = 1'b1;
      FN_JE:  jump = flags.equal;
      FN_JNE: jump = !flags.equal;
      FN_JZ:  jump = flags.zero;
      FN_JNZ: jump = !flags.zero;
      FN_JL:  jump = flags.less;
      FN_JLE: jump = flags.less || flags.equal;
      FN_JG:  jump = flags.greater;
      FN_JGE: jump = flags.greater || flags.equal;
      default: begin wr = 1'b0; jump = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      flags     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // in finish the result register is reloaded instead
      if (rsp_valid && rsp.ready && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            func_q <= req.func;
            src_q  <= req.src_value;
            if (use_alu) begin
              state <= ST_ALU;
            end else if (use_md) begin
              state <= ST_MD;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_ALU: begin
          if (alu_res.done) begin
            state <= ST_FINISH;
          end
        end
        ST_MD: begin
          if (md_res.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            flags         <= flags_next;
            rsp_valid     <= 1'b1;
            rsp_dst_write <= wr;
            rsp_dst_value <= wr ? wr_value : '0;
            rsp_pc_load   <= jump;
            rsp_new_pc    <= jump ? src_q : '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.dst_write      = rsp_dst_write;
  assign rsp.dst_value      = rsp_dst_value;
  assign rsp.pc_load        = rsp_pc_load;
  assign rsp.new_pc         = rsp_new_pc;
  assign rsp.flag_greater   = flags.greater;
  assign rsp.flag_less      = flags.less;
  assign rsp.flag_equal     = flags.equal;
  assign rsp.flag_zero      = flags.zero;
  assign rsp.flag_overflow  = flags.overflow;
  assign rsp.flag_underflow = flags.underflow;
  assign rsp.halted         = flags.halt;

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    flags.halt |=> flags.halt)
    else $error("halt flag dropped without reset");

  a_write_xor_jump: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_dst_write && rsp_pc_load))
    else $error("result carries both a write and a jump");

  a_idle_value_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_dst_write) |-> (rsp_dst_value == '0))
    else $error("destination value not zero without write");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted word did not start execution");

  a_flags_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FINISH) |=> $stable(flags))
    else $error("flags changed outside result write");
`endif

endmodule

>>> rtl/vab_serial_alu.sv
`timescale 1ns / 1ps
// bit-serial alu: add, sub, inc, dec, move, shifts and compare, one bit per cycle
// depends on vab_pkg

module vab_serial_alu import vab_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  alu_ctrl_t             ctrl,
  input  logic [WORD_WIDTH-1:0] a,
  input  logic [WORD_WIDTH-1:0] s,
  output alu_res_t              res
);

  logic                  run;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  alu_op_t               op_q;
  logic [WORD_WIDTH-1:0] a_sr;
  logic [WORD_WIDTH-1:0] s_sr;
  logic [WORD_WIDTH-1:0] r_sr;
  logic                  carry;
  logic                  lag;
  logic                  ne;
  logic                  nz;

  logic x_bit;
  logic y_bit;
  logic sum_bit;
  logic carry_next;

  // operand bits of the current step, lsb first
  always_comb begin
    x_bit = s_sr[0];
    y_bit = 1'b0;
    case (op_q)
      AOP_MOV: begin x_bit = s_sr[0]; y_bit = 1'b0;     end
      AOP_INC: begin x_bit = s_sr[0]; y_bit = 1'b0;     end
      AOP_DEC: begin x_bit = s_sr[0]; y_bit = 1'b1;     end
      AOP_ADD: begin x_bit = a_sr[0]; y_bit = s_sr[0];  end
      AOP_SUB: begin x_bit = a_sr[0]; y_bit = ~s_sr[0]; end
      AOP_CMP: begin x_bit = a_sr[0]; y_bit = ~s_sr[0]; end
      AOP_SHL: begin x_bit = lag;     y_bit = 1'b0;     end
      AOP_SHR: begin x_bit = s_sr[1]; y_bit = 1'b0;     end
      default: begin x_bit = s_sr[0]; y_bit = 1'b0;     end
    endcase
    sum_bit    = x_bit ^ y_bit ^ carry;
    carry_next = (x_bit & y_bit) | (x_bit & carry) | (y_bit & carry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      op_q  <= ctrl.op;
      a_sr  <= a;
      s_sr  <= s;
      // subtract, compare and increment start with a carry in
      carry <= (ctrl.op inside {AOP_INC, AOP_SUB, AOP_CMP});
      lag   <= 1'b0;
      ne    <= 1'b0;
      nz    <= 1'b0;
    end else if (run) begin
      a_sr  <= {1'b0, a_sr[WORD_WIDTH-1:1]};
      s_sr  <= {1'b0, s_sr[WORD_WIDTH-1:1]};
      r_sr  <= {sum_bit, r_sr[WORD_WIDTH-1:1]};
      carry <= carry_next;
      lag   <= s_sr[0];
      ne    <= ne | (a_sr[0] ^ s_sr[0]);
      nz    <= nz | a_sr[0];
    end
  end

  assign res.done  = done;
  assign res.value = r_sr;
  assign res.carry = carry;
  assign res.ne    = ne;
  assign res.nz    = nz;

endmodule

>>> rtl/vab_muldiv.sv
`timescale 1ns / 1ps
// radix-2 iterative unit: shift-add multiply and restoring divide, one bit per cycle
// depends on vab_pkg

module vab_muldiv import vab_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  md_ctrl_t              ctrl,
  input  logic [WORD_WIDTH-1:0] a,
  input  logic [WORD_WIDTH-1:0] s,
  output md_res_t               res
);

  logic                  run;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic                  is_div_q;
  logic [WORD_WIDTH-1:0] hi;
  logic [WORD_WIDTH-1:0] lo;
  logic [WORD_WIDTH-1:0] s_q;

  logic [WORD_WIDTH:0]   mul_sum;
  logic [WORD_WIDTH:0]   div_sh;
  logic [WORD_WIDTH+1:0] div_diff;
  logic                  borrow;

  always_comb begin
    mul_sum  = {1'b0, hi} + (lo[0] ? {1'b0, s_q} : '0);
    div_sh   = {hi, lo[WORD_WIDTH-1]};
    div_diff = {1'b0, div_sh} - {2'b00, s_q};
    borrow   = div_diff[WORD_WIDTH+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // hi holds partial product or remainder, lo multiplier/product or dividend/quotient
  // a zero divisor never borrows, so the quotient comes out all ones
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      is_div_q <= ctrl.is_div;
      hi       <= '0;
      lo       <= a;
      s_q      <= s;
    end else if (run) begin
      if (is_div_q) begin
        hi <= borrow ? div_sh[WORD_WIDTH-1:0] : div_diff[WORD_WIDTH-1:0];
        lo <= {lo[WORD_WIDTH-2:0], ~borrow};
      end else begin
        {hi, lo} <= {mul_sum, lo[WORD_WIDTH-1:1]};
      end
    end
  end

  assign res.done  = done;
  assign res.value = lo;
  assign res.ovf   = |hi;

endmodule

>>> test/vm_alu_branch_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of vm_alu_branch_unit: directed and random words,
// expected results from an in-bench flag and value model; uses vab_pkg and both channel interfaces

module vm_alu_branch_unit_tb;
  import vab_pkg::*;

  localparam logic [4:0] FN_CODE_MAX  = 5'd31;
  localparam int         IDLE_PCT     = 37;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         RAND_WORDS   = 1950;

  typedef struct {
    logic [4:0]  func;
    logic [15:0] acc;
    logic [15:0] src;
    bit          drain;
  } req_word_t;

  typedef struct {
    logic        dst_write;
    logic [15:0] dst_value;
    logic        pc_load;
    logic [15:0] new_pc;
    flags_t      flags;
  } rsp_word_t;

  logic clk;
  logic rst = 1'b1;

  // tb-side drive registers, known from time zero
  logic        drv_valid = 1'b0;
  logic [4:0]  drv_func  = '0;
  logic [15:0] drv_acc   = '0;
  logic [15:0] drv_src   = '0;
  logic        drv_ready = 1'b0;

  vab_req_if req ();
  vab_rsp_if rsp ();

  assign req.valid     = drv_valid;
  assign req.func      = drv_func;
  assign req.acc_value = drv_acc;
  assign req.src_value = drv_src;
  assign rsp.ready     = drv_ready;

  vm_alu_branch_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  req_word_t req_backlog[$];
  rsp_word_t rsp_expected[$];
  flags_t    model_flags = '0;
  logic      req_word_taken = 1'b0;
  int        err_count = 0;
  int        cycle_count = 0;
  int        stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // no idling at all inside this window
  function automatic bit calm_window();
    return (cycle_count >= 12000) && (cycle_count < 18000);
  endfunction

  function automatic bit take_idle();
    if (calm_window()) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15));
      3: return 16'h8000 | 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_word(input logic [4:0] f, input logic [15:0] a, input logic [15:0] s,
                          input bit drain = 1'b0);
    req_word_t w;
    w.func  = f;
    w.acc   = a;
    w.src   = s;
    w.drain = drain;
    req_backlog.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic execute_word(input req_word_t w, output rsp_word_t r);
    logic [15:0] a;
    logic [15:0] s;
    logic [16:0] sum;
    logic [31:0] prod;
    a = w.acc;
    s = w.src;
    r.dst_write = 1'b0;
    r.dst_value = '0;
    r.pc_load   = 1'b0;
    r.new_pc    = '0;
    case (w.func)
      FN_HLT: model_flags.halt = 1'b1;
      FN_CMP: begin
        model_flags.greater = a > s;
        model_flags.less    = a < s;
        model_flags.equal   = a == s;
        model_flags.zero    = a == 16'h0000;
      end
      FN_MOV: begin
        r.dst_write = 1'b1;
        r.dst_value = s;
      end
      FN_INC: begin
        r.dst_write = 1'b1;
        r.dst_value = s + 16'd1;
        model_flags.overflow = s == 16'hFFFF;
      end
      FN_DEC: begin
        r.dst_write = 1'b1;
        r.dst_value = s - 16'd1;
        model_flags.underflow = s == 16'h0000;
      end
      FN_ADD: begin
        sum = {1'b0, a} + {1'b0, s};
        r.dst_write = 1'b1;
        r.dst_value = sum[15:0];
        model_flags.overflow = sum[16];
      end
      FN_SUB: begin
        r.dst_write = 1'b1;
        r.dst_value = a - s;
        model_flags.underflow = a < s;
      end
      FN_MUL: begin
        prod = a * s;
        r.dst_write = 1'b1;
        r.dst_value = prod[15:0];
        model_flags.overflow = |prod[31:16];
      end
      FN_DIV: begin
        r.dst_write = 1'b1;
        r.dst_value = (s == 16'h0000) ? 16'hFFFF : a / s;
      end
      FN_SHL: begin
        r.dst_write = 1'b1;
        r.dst_value = s << 1;
      end
      FN_SHR: begin
        r.dst_write = 1'b1;
        r.dst_value = s >> 1;
      end
      FN_JMP: r.pc_load = 1'b1;
      FN_JE:  r.pc_load = model_flags.equal;
      FN_JNE: r.pc_load = !model_flags.equal;
      FN_JZ:  r.pc_load = model_flags.zero;
      FN_JNZ: r.pc_load = !model_flags.zero;
      FN_JL:  r.pc_load = model_flags.less;
      FN_JLE: r.pc_load = model_flags.less || model_flags.equal;
      FN_JG:  r.pc_load = model_flags.greater;
      FN_JGE: r.pc_load = model_flags.greater || model_flags.equal;
      default: ;
    endcase
    if (r.pc_load) r.new_pc = s;
    r.flags = model_flags;
  endtask

  // request driver: one word at a time, held until accepted
  always @(negedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (drv_valid && !req_word_taken) begin
      drv_valid <= 1'b1;
    end else if (req_backlog.size() != 0 && !(req_backlog[0].drain && rsp_expected.size() != 0)
                 && !take_idle()) begin
      drv_func  <= req_backlog[0].func;
      drv_acc   <= req_backlog[0].acc;
      drv_src   <= req_backlog[0].src;
      drv_valid <= 1'b1;
      void'(req_backlog.pop_front());
    end else begin
      drv_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) drv_ready <= 1'b0;
    else     drv_ready <= !take_idle();
  end

  // monitor: check results, then predict newly accepted words
  always @(posedge clk) begin
    rsp_word_t want;
    rsp_word_t got;
    req_word_t w;
    if (rst) begin
      req_word_taken <= 1'b0;
    end else begin
      cycle_count++;
      req_word_taken <= req.valid && req.ready;
      if (rsp.valid && rsp.ready) begin
        if (rsp_expected.size() == 0) begin
          report_mismatch("unexpected result word", rsp.dst_value, 16'h0000);
        end else begin
          want = rsp_expected.pop_front();
          check_field("dst_write", 16'(rsp.dst_write), 16'(want.dst_write));
          check_field("dst_value", rsp.dst_value, want.dst_value);
          check_field("pc_load", 16'(rsp.pc_load), 16'(want.pc_load));
          check_field("new_pc", rsp.new_pc, want.new_pc);
          check_field("flag_greater", 16'(rsp.flag_greater), 16'(want.flags.greater));
          check_field("flag_less", 16'(rsp.flag_less), 16'(want.flags.less));
          check_field("flag_equal", 16'(rsp.flag_equal), 16'(want.flags.equal));
          check_field("flag_zero", 16'(rsp.flag_zero), 16'(want.flags.zero));
          check_field("flag_overflow", 16'(rsp.flag_overflow), 16'(want.flags.overflow));
          check_field("flag_underflow", 16'(rsp.flag_underflow), 16'(want.flags.underflow));
          check_field("halted", 16'(rsp.halted), 16'(want.flags.halt));
        end
      end
      if (req.valid && req.ready) begin
        w.func  = req.func;
        w.acc   = req.acc_value;
        w.src   = req.src_value;
        w.drain = 1'b0;
        execute_word(w, got);
        rsp_expected.push_back(got);
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        stall_cycles = 0;
      end else if (req_backlog.size() != 0 || rsp_expected.size() != 0 || drv_valid) begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [4:0] f;
    // directed: compares with the jumps that test them, then other words
    add_word(FN_CMP, 16'h0000, 16'h0000);
    add_word(FN_JE, 16'h1111, 16'hFFFF);
    add_word(FN_JZ, 16'h2222, 16'h0001);
    add_word(FN_JLE, 16'h0000, 16'h8000);
    add_word(FN_CMP, 16'hFFFF, 16'h0000);
    add_word(FN_JG, 16'h0000, 16'h1234);
    add_word(FN_JNZ, 16'h0000, 16'h4321);
    add_word(FN_CMP, 16'h0000, 16'hFFFF);
    add_word(FN_JL, 16'hFFFF, 16'hABCD);
    add_word(FN_JGE, 16'hFFFF, 16'h5555);
    add_word(FN_INC, 16'h0000, 16'hFFFF);
    add_word(FN_DEC, 16'hFFFF, 16'h0000);
    add_word(FN_ADD, 16'hFFFF, 16'hFFFF);
    add_word(FN_SUB, 16'hFFFF, 16'hFFFF);
    add_word(FN_SUB, 16'h0000, 16'h0001);
    add_word(FN_MUL, 16'hFFFF, 16'hFFFF);
    add_word(FN_MUL, 16'h00FF, 16'h0101);
    add_word(FN_DIV, 16'h1234, 16'h0000);
    add_word(FN_DIV, 16'hFFFF, 16'h0001);
    add_word(FN_SHL, 16'h0000, 16'h8001);
    add_word(FN_SHR, 16'hFFFF, 16'hFFFF);
    add_word(FN_MOV, 16'h0000, 16'hFFFF);
    add_word(FN_JMP, 16'h0000, 16'hFFFF);
    add_word(FN_NOP, 16'hFFFF, 16'hFFFF);
    add_word(FN_CODE_MAX, 16'hFFFF, 16'hFFFF);
    add_word(FN_HLT, 16'h0000, 16'h0000);
    // halted unit keeps executing
    add_word(FN_ADD, 16'h7FFF, 16'h0001);

    for (int i = 0; i < RAND_WORDS; i++) begin
      bit drain;
      // two-wide windows, since a compare-jump pair advances i by two
      drain = (i == 600) || (i == 601) || (i == 1400) || (i == 1401);
      case ($urandom_range(9))
        0, 1, 2: begin
          // compare then a conditional jump on its flags
          add_word(FN_CMP, rand_value(), rand_value(), drain);
          f = 5'($urandom_range(FN_JE, FN_JGE));
          add_word(f, rand_value(), rand_value());
          i++;
        end
        3: begin
          f = 5'($urandom_range(FN_JGE + 1, FN_CODE_MAX));
          add_word(f, rand_value(), rand_value(), drain);
        end
        default: begin
          f = 5'($urandom_range(FN_HLT, FN_JGE));
          add_word(f, rand_value(), rand_value(), drain);
        end
      endcase
    end

    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (req_backlog.size() != 0 || drv_valid || rsp_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && rsp_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
